FILE: rtl/tvdt_pkg.sv
`default_nettype none
package tvdt_pkg;

  // Fraction bits of the depth result
  localparam int unsigned DEPTH_FRAC_BITS = 16;
  localparam int unsigned FRAC_SHIFT = DEPTH_FRAC_BITS - 2;

  // Configuration port
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;

  // round(1e-6 * 2^56)
  localparam logic [63:0] DET_MIN = 64'd72057594038;

  // Datapath widths
  localparam int unsigned PROD_W = 80;
  localparam int unsigned NUM_W  = 82;
  localparam int unsigned MAG_W  = 81;
  localparam int unsigned SH_W   = MAG_W + FRAC_SHIFT;
  localparam int unsigned HI_W   = SH_W - 32;
  localparam int unsigned CMP_W  = (HI_W > 64) ? HI_W : 64;
  localparam int unsigned QUO_W  = 32;

  typedef enum logic [2:0] {
    REG_ROT0 = 3'd0,
    REG_ROT1 = 3'd1,
    REG_ROT2 = 3'd2,
    REG_TX   = 3'd3,
    REG_TY   = 3'd4,
    REG_TZ   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][47:0] rot;
    logic [2:0][31:0] trans;
  } cfg_t;

  typedef struct packed {
    logic        [31:0] aa;
    logic        [31:0] cc;
    logic signed [33:0] ac;
    logic signed [49:0] at;
    logic signed [49:0] ct;
  } dots_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [63:0]      det;
    logic             ok;
  } quot_in_t;

  // Q28 to Q14, round half up, saturate to 16 bits
  function automatic logic signed [15:0] round_q14(input logic signed [34:0] s);
    logic signed [34:0] r;
    r = (s + 35'sd8192) >>> 14;
    if (r > 35'sd32767) begin
      return 16'sh7fff;
    end else if (r < -35'sd32768) begin
      return 16'sh8000;
    end else begin
      return r[15:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tvdt_in_if.sv
`default_nettype none
interface tvdt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] ref_dir_x;
  logic signed [15:0] ref_dir_y;
  logic signed [15:0] ref_dir_z;
  logic signed [15:0] cur_dir_x;
  logic signed [15:0] cur_dir_y;
  logic signed [15:0] cur_dir_z;

  modport source (
    output valid, ref_dir_x, ref_dir_y, ref_dir_z, cur_dir_x, cur_dir_y, cur_dir_z,
    input  ready
  );
  modport sink (
    input  valid, ref_dir_x, ref_dir_y, ref_dir_z, cur_dir_x, cur_dir_y, cur_dir_z,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/tvdt_out_if.sv
`default_nettype none
interface tvdt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] depth_value;
  logic        depth_ok;

  modport source (
    output valid, depth_value, depth_ok,
    input  ready
  );
  modport sink (
    input  valid, depth_value, depth_ok,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/tvdt_cfg.sv
`default_nettype none
module tvdt_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tvdt_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [tvdt_pkg::DATA_W-1:0]   pwdata,
  output logic      [tvdt_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output tvdt_pkg::cfg_t                     cfg_o
);

  tvdt_pkg::cfg_t     cfg_q;
  tvdt_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = tvdt_pkg::reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot[0]   <= 48'd16384;
      cfg_q.rot[1]   <= 48'd16384 << 16;
      cfg_q.rot[2]   <= 48'd16384 << 32;
      cfg_q.trans[0] <= '0;
      cfg_q.trans[1] <= '0;
      cfg_q.trans[2] <= '0;
    end else if (wr_en) begin
      case (idx)
        tvdt_pkg::REG_ROT0: cfg_q.rot[0]   <= pwdata[47:0];
        tvdt_pkg::REG_ROT1: cfg_q.rot[1]   <= pwdata[47:0];
        tvdt_pkg::REG_ROT2: cfg_q.rot[2]   <= pwdata[47:0];
        tvdt_pkg::REG_TX:   cfg_q.trans[0] <= pwdata[31:0];
        tvdt_pkg::REG_TY:   cfg_q.trans[1] <= pwdata[31:0];
        tvdt_pkg::REG_TZ:   cfg_q.trans[2] <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tvdt_pkg::REG_ROT0: prdata = {16'd0, cfg_q.rot[0]};
      tvdt_pkg::REG_ROT1: prdata = {16'd0, cfg_q.rot[1]};
      tvdt_pkg::REG_ROT2: prdata = {16'd0, cfg_q.rot[2]};
      tvdt_pkg::REG_TX:   prdata = {32'd0, cfg_q.trans[0]};
      tvdt_pkg::REG_TY:   prdata = {32'd0, cfg_q.trans[1]};
      tvdt_pkg::REG_TZ:   prdata = {32'd0, cfg_q.trans[2]};
      default:            prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/tvdt_geom.sv
`default_nettype none
module tvdt_geom (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [2:0][15:0] ref_i,
  input  wire logic [2:0][15:0] cur_i,
  input  wire tvdt_pkg::cfg_t   cfg_i,
  output logic                  valid_o,
  output tvdt_pkg::dots_t       dots_o
);

  // stage 1: rotation products
  logic signed [31:0] rprod_d [3][3];
  logic signed [31:0] rprod_q [3][3];
  logic [2:0][15:0]   cur1_q;
  // stage 2: rotated bearing
  logic signed [15:0] a_d [3];
  logic signed [15:0] a_q [3];
  logic [2:0][15:0]   cur2_q;
  // stage 3: dot product terms
  logic signed [31:0] aa_q [3];
  logic signed [31:0] cc_q [3];
  logic signed [31:0] ac_q [3];
  logic signed [47:0] at_q [3];
  logic signed [47:0] ct_q [3];
  // stage 4: dot products
  tvdt_pkg::dots_t    dots_d;
  tvdt_pkg::dots_t    dots_q;
  logic [3:0]         v_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rprod_d[i][j] = $signed(cfg_i.rot[i][16*j +: 16]) * $signed(ref_i[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_d[i] = tvdt_pkg::round_q14(35'(rprod_q[i][0]) + 35'(rprod_q[i][1]) +
                                   35'(rprod_q[i][2]));
    end
  end

  always_comb begin
    dots_d.aa = 32'(aa_q[0]) + 32'(aa_q[1]) + 32'(aa_q[2]);
    dots_d.cc = 32'(cc_q[0]) + 32'(cc_q[1]) + 32'(cc_q[2]);
    dots_d.ac = 34'(ac_q[0]) + 34'(ac_q[1]) + 34'(ac_q[2]);
    dots_d.at = 50'(at_q[0]) + 50'(at_q[1]) + 50'(at_q[2]);
    dots_d.ct = 50'(ct_q[0]) + 50'(ct_q[1]) + 50'(ct_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rprod_q <= rprod_d;
      cur1_q  <= cur_i;
      a_q     <= a_d;
      cur2_q  <= cur1_q;
      for (int k = 0; k < 3; k++) begin
        aa_q[k] <= a_q[k] * a_q[k];
        cc_q[k] <= $signed(cur2_q[k]) * $signed(cur2_q[k]);
        ac_q[k] <= a_q[k] * $signed(cur2_q[k]);
        at_q[k] <= a_q[k] * $signed(cfg_i.trans[k]);
        ct_q[k] <= $signed(cur2_q[k]) * $signed(cfg_i.trans[k]);
      end
      dots_q <= dots_d;
    end
  end

  assign valid_o = v_q[3];
  assign dots_o  = dots_q;

endmodule
`default_nettype wire

FILE: rtl/tvdt_num.sv
`default_nettype none
module tvdt_num (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire tvdt_pkg::dots_t dots_i,
  output logic                 valid_o,
  output tvdt_pkg::quot_in_t   quot_o
);

  localparam int unsigned ProdW = tvdt_pkg::PROD_W;
  localparam int unsigned NumW  = tvdt_pkg::NUM_W;
  localparam int unsigned MagW  = tvdt_pkg::MAG_W;

  // stage 5: magnitudes and signs
  logic [31:0] aa5_q, cc5_q, acm5_q;
  logic [47:0] atm5_q, ctm5_q;
  logic        s1_5_q, s2_5_q;
  // stage 6: partial products
  logic [63:0] aacc_q, acsq_q;
  logic [55:0] p1lo_q, p1hi_q, p2lo_q, p2hi_q;
  logic        s1_6_q, s2_6_q;
  // stage 7: determinant and product magnitudes
  logic [63:0]      det7_q;
  logic [ProdW-1:0] p1_q, p2_q;
  logic             s1_7_q, s2_7_q;
  // stage 8: signed terms, determinant test
  logic [63:0]         det8_q;
  logic signed [ProdW:0] sp1_q, sp2_q;
  logic                ok8_q;
  // stage 9: numerator
  logic [63:0]          det9_q;
  logic signed [NumW-1:0] num_q;
  logic                 ok9_q;
  // stage 10: numerator magnitude
  tvdt_pkg::quot_in_t   quot_q;
  logic [NumW-1:0]      num_abs;
  logic [33:0]          ac_abs;
  logic [49:0]          at_abs, ct_abs;
  logic [5:0]           v_q;

  assign ac_abs  = dots_i.ac[33] ? 34'(-dots_i.ac) : 34'(dots_i.ac);
  assign at_abs  = dots_i.at[49] ? 50'(-dots_i.at) : 50'(dots_i.at);
  assign ct_abs  = dots_i.ct[49] ? 50'(-dots_i.ct) : 50'(dots_i.ct);
  assign num_abs = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aa5_q  <= dots_i.aa;
      cc5_q  <= dots_i.cc;
      acm5_q <= ac_abs[31:0];
      atm5_q <= at_abs[47:0];
      ctm5_q <= ct_abs[47:0];
      s1_5_q <= dots_i.at[49];
      s2_5_q <= dots_i.ac[33] ^ dots_i.ct[49];

      aacc_q <= 64'(aa5_q) * 64'(cc5_q);
      acsq_q <= 64'(acm5_q) * 64'(acm5_q);
      p1lo_q <= 56'(cc5_q) * 56'(atm5_q[23:0]);
      p1hi_q <= 56'(cc5_q) * 56'(atm5_q[47:24]);
      p2lo_q <= 56'(acm5_q) * 56'(ctm5_q[23:0]);
      p2hi_q <= 56'(acm5_q) * 56'(ctm5_q[47:24]);
      s1_6_q <= s1_5_q;
      s2_6_q <= s2_5_q;

      det7_q <= aacc_q - acsq_q;
      p1_q   <= {p1hi_q, 24'd0} + ProdW'(p1lo_q);
      p2_q   <= {p2hi_q, 24'd0} + ProdW'(p2lo_q);
      s1_7_q <= s1_6_q;
      s2_7_q <= s2_6_q;

      det8_q <= det7_q;
      ok8_q  <= det7_q >= tvdt_pkg::DET_MIN;
      sp1_q  <= s1_7_q ? -$signed({1'b0, p1_q}) : $signed({1'b0, p1_q});
      sp2_q  <= s2_7_q ? -$signed({1'b0, p2_q}) : $signed({1'b0, p2_q});

      det9_q <= det8_q;
      ok9_q  <= ok8_q;
      num_q  <= NumW'(sp1_q) - NumW'(sp2_q);

      quot_q.det <= det9_q;
      quot_q.ok  <= ok9_q;
      quot_q.mag <= num_abs[MagW-1:0];
    end
  end

  assign valid_o = v_q[5];
  assign quot_o  = quot_q;

endmodule
`default_nettype wire

FILE: rtl/tvdt_div.sv
`default_nettype none
module tvdt_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire tvdt_pkg::quot_in_t quot_i,
  output logic                    valid_o,
  output logic [31:0]             value_o,
  output logic                    ok_o
);

  localparam int unsigned ShW  = tvdt_pkg::SH_W;
  localparam int unsigned CmpW = tvdt_pkg::CMP_W;
  localparam int unsigned QuoW = tvdt_pkg::QUO_W;

  logic [ShW-1:0]  sh;
  logic [CmpW-1:0] hi_x;
  logic [CmpW-1:0] det_x;

  logic [63:0]     rem_q [QuoW+1];
  logic [QuoW-1:0] quo_q [QuoW+1];
  logic [31:0]     low_q [QuoW+1];
  logic [63:0]     det_q [QuoW+1];
  logic [QuoW:0]   ok_q;
  logic [QuoW:0]   sat_q;
  logic [QuoW:0]   v_q;

  logic [63:0]     rem_d [QuoW];
  logic [QuoW-1:0] quo_d [QuoW];

  logic [31:0] value_q;
  logic        ok_out_q;
  logic        v_out_q;

  // Scale the numerator, then split into a leading remainder and 32 bits to shift in
  assign sh    = ShW'(quot_i.mag) << tvdt_pkg::FRAC_SHIFT;
  assign hi_x  = CmpW'(sh[ShW-1:32]);
  assign det_x = CmpW'(quot_i.det);

  always_comb begin
    logic [64:0] trial;
    logic        ge;
    for (int k = 0; k < QuoW; k++) begin
      trial    = {rem_q[k], low_q[k][31]};
      ge       = trial >= {1'b0, det_q[k]};
      rem_d[k] = ge ? 64'(trial - {1'b0, det_q[k]}) : trial[63:0];
      quo_d[k] = {quo_q[k][QuoW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      v_out_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[QuoW-1:0], valid_i};
      v_out_q <= v_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hi_x[63:0];
      quo_q[0] <= '0;
      low_q[0] <= sh[31:0];
      det_q[0] <= quot_i.det;
      ok_q[0]  <= quot_i.ok;
      sat_q[0] <= hi_x >= det_x;
      for (int k = 0; k < QuoW; k++) begin
        rem_q[k+1] <= rem_d[k];
        quo_q[k+1] <= quo_d[k];
        low_q[k+1] <= {low_q[k][30:0], 1'b0};
        det_q[k+1] <= det_q[k];
        ok_q[k+1]  <= ok_q[k];
        sat_q[k+1] <= sat_q[k];
      end
      ok_out_q <= ok_q[QuoW];
      if (!ok_q[QuoW]) begin
        value_q <= '0;
      end else if (sat_q[QuoW]) begin
        value_q <= '1;
      end else begin
        value_q <= quo_q[QuoW];
      end
    end
  end

  assign valid_o = v_out_q;
  assign value_o = value_q;
  assign ok_o    = ok_out_q;

  a_rem_below_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QuoW] && ok_q[QuoW] && !sat_q[QuoW] |-> rem_q[QuoW] < det_q[QuoW])
    else $error("division remainder not below divisor");

  a_ok_det_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QuoW] && ok_q[QuoW] |-> det_q[QuoW] >= tvdt_pkg::DET_MIN)
    else $error("passed item with determinant below threshold");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(v_q) && $stable(v_out_q))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

FILE: rtl/two_view_depth_triangulation.sv
`default_nettype none
// Two-view triangulation: for each pair of Q1.14 bearings (reference, current) the block
// rotates the reference ray by the configured rotation, tests the determinant of the 2x2
// normal matrix against 1e-6, and returns the least-squares depth along the reference ray
// as unsigned Q16.16, saturated to 0xFFFFFFFF; depth_ok is low and depth 0 when the rays
// are too close to parallel. The datapath is a fixed 44-stage pipeline: ten stages of
// rotation, dot products and numerator, a stage that scales the numerator and flags
// overflow, a 32-stage restoring divider that retires one quotient bit per stage, and an
// output register. One transaction is accepted every cycle while the output is taken;
// any output stall halts the whole pipeline. Write the rotation and translation
// registers only while no transaction is in flight.
module two_view_depth_triangulation (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  tvdt_in_if.sink                          in_i,
  tvdt_out_if.source                       out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tvdt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tvdt_pkg::DATA_W-1:0] pwdata,
  output logic      [tvdt_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  tvdt_pkg::cfg_t     cfg;
  tvdt_pkg::dots_t    dots;
  tvdt_pkg::quot_in_t quot;
  logic               en;
  logic               geom_valid;
  logic               num_valid;
  logic               div_valid;
  logic [31:0]        div_value;
  logic               div_ok;

  // advance every stage unless the result at the output is held
  assign en = !div_valid || out_o.ready;
  assign in_i.ready = en;

  tvdt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tvdt_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .ref_i   ({in_i.ref_dir_z, in_i.ref_dir_y, in_i.ref_dir_x}),
    .cur_i   ({in_i.cur_dir_z, in_i.cur_dir_y, in_i.cur_dir_x}),
    .cfg_i   (cfg),
    .valid_o (geom_valid),
    .dots_o  (dots)
  );

  tvdt_num u_num (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (geom_valid),
    .dots_i  (dots),
    .valid_o (num_valid),
    .quot_o  (quot)
  );

  tvdt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (num_valid),
    .quot_i  (quot),
    .valid_o (div_valid),
    .value_o (div_value),
    .ok_o    (div_ok)
  );

  assign out_o.valid       = div_valid;
  assign out_o.depth_value = div_value;
  assign out_o.depth_ok    = div_ok;

endmodule
`default_nettype wire

FILE: test/tb_two_view_depth_triangulation.sv
`default_nettype none
module tb_two_view_depth_triangulation;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] rx, ry, rz, cx, cy, cz;
  } bearings_t;

  typedef struct packed {
    logic [31:0] depth;
    logic        ok;
  } depth_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [tvdt_pkg::ADDR_W-1:0] paddr = '0;
  logic [tvdt_pkg::DATA_W-1:0] pwdata = '0;
  logic [tvdt_pkg::DATA_W-1:0] prdata;
  logic pready;

  tvdt_in_if  in_if ();
  tvdt_out_if out_if ();

  two_view_depth_triangulation dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_i (in_if), .out_o (out_if),
    .psel (psel), .penable (penable), .pwrite (pwrite), .paddr (paddr),
    .pwdata (pwdata), .prdata (prdata), .pready (pready)
  );

  // Shadow of the configuration registers
  logic [47:0] rot_q [3];
  logic [31:0] trans_q [3];

  depth_t depth_q [$];
  int unsigned n_sent = 0, n_checked = 0, n_ok = 0, n_sat = 0, n_mismatch = 0, n_cfg = 0;
  bit calm = 1'b0;
  int stall_left = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    in_if.valid = 1'b0;
    {in_if.ref_dir_x, in_if.ref_dir_y, in_if.ref_dir_z} = '0;
    {in_if.cur_dir_x, in_if.cur_dir_y, in_if.cur_dir_z} = '0;
    out_if.ready = 1'b0;
  end

  function automatic depth_t triangulate(bearings_t b);
    longint f[3], c[3], a[3], t[3], s, ac, at, ct;
    logic [63:0] aa, cc, mac, det;
    logic signed [127:0] cc_w, at_w, ac_w, ct_w, num;
    logic [127:0] mag, quo;
    depth_t r;
    f = '{b.rx, b.ry, b.rz};
    c = '{b.cx, b.cy, b.cz};
    for (int k = 0; k < 3; k++) t[k] = longint'($signed(trans_q[k]));
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int j = 0; j < 3; j++) s += longint'($signed(rot_q[i][16*j +: 16])) * f[j];
      s = (s + 8192) >>> 14;
      a[i] = (s > 32767) ? 32767 : (s < -32768) ? -32768 : s;
    end
    aa = '0; cc = '0; ac = 0; at = 0; ct = 0;
    for (int k = 0; k < 3; k++) begin
      aa += 64'(a[k] * a[k]);
      cc += 64'(c[k] * c[k]);
      ac += a[k] * c[k];
      at += a[k] * t[k];
      ct += c[k] * t[k];
    end
    mac = (ac < 0) ? 64'(-ac) : 64'(ac);
    det = aa * cc - mac * mac;
    r = '0;
    if (det < tvdt_pkg::DET_MIN) return r;
    cc_w = cc; at_w = at; ac_w = ac; ct_w = ct;
    num = cc_w * at_w - ac_w * ct_w;
    mag = (num < 0) ? -num : num;
    mag = mag << tvdt_pkg::FRAC_SHIFT;
    quo = mag / {64'd0, det};
    r.depth = (quo[127:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
    r.ok = 1'b1;
    return r;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (depth_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result depth=%h ok=%b",
                                       out_if.depth_value, out_if.depth_ok);
      end else begin
        depth_t e;
        e = depth_q.pop_front();
        n_checked++;
        if (e.ok) n_ok++;
        if (e.depth == 32'hFFFF_FFFF) n_sat++;
        if (out_if.depth_value !== e.depth || out_if.depth_ok !== e.ok) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: depth exp %h got %h, ok exp %b got %b",
                     e.depth, out_if.depth_value, e.ok, out_if.depth_ok);
        end
      end
    end
  end

  // Receiver stalls
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
    end
  end

  task automatic send_bearings(bearings_t b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    {in_if.ref_dir_x, in_if.ref_dir_y, in_if.ref_dir_z} <= {b.rx, b.ry, b.rz};
    {in_if.cur_dir_x, in_if.cur_dir_y, in_if.cur_dir_z} <= {b.cx, b.cy, b.cz};
    do @(posedge clk_i); while (!in_if.ready);
    depth_q.push_back(triangulate(b));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (depth_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_reg(tvdt_pkg::reg_idx_e idx, logic [63:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= tvdt_pkg::ADDR_W'(int'(idx) * 8);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx <= tvdt_pkg::REG_ROT2) rot_q[int'(idx)] = value[47:0];
    else trans_q[int'(idx) - int'(tvdt_pkg::REG_TX)] = value[31:0];
    n_cfg++;
  endtask

  task automatic load_pose(logic [47:0] r0, r1, r2, logic [31:0] tx, ty, tz);
    drain_results();
    write_reg(tvdt_pkg::REG_ROT0, r0);
    write_reg(tvdt_pkg::REG_ROT1, r1);
    write_reg(tvdt_pkg::REG_ROT2, r2);
    write_reg(tvdt_pkg::REG_TX, tx);
    write_reg(tvdt_pkg::REG_TY, ty);
    write_reg(tvdt_pkg::REG_TZ, tz);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'(-16384);
      1: return 16'sd16384;
      2: return 16'($urandom());
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic bearings_t rand_bearings();
    bearings_t b;
    b = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    // nearly parallel rays now and then, to hit the determinant threshold
    if ($urandom_range(0, 7) == 0) begin
      b.cx = b.rx + 16'($signed($urandom_range(0, 6)) - 3);
      b.cy = b.ry + 16'($signed($urandom_range(0, 6)) - 3);
      b.cz = b.rz + 16'($signed($urandom_range(0, 6)) - 3);
    end
    return b;
  endfunction

  function automatic logic [47:0] rand_row();
    logic [47:0] r;
    for (int j = 0; j < 3; j++)
      r[16*j +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                  : 16'($urandom_range(0, 32768) - 16384);
    return r;
  endfunction

  task automatic test_directed();
    load_pose(48'd16384, 48'd16384 << 16, 48'd16384 << 32,
              32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000);
    send_bearings({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    send_bearings({16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0});
    send_bearings({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});            // zero rays
    send_bearings({16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});    // parallel
    send_bearings({-16'sd16384, -16'sd16384, -16'sd16384,
                   16'sd16384, 16'sd16384, -16'sd16384});
    send_bearings({16'sd11585, 16'sd11585, 16'sd0, 16'sd11585, -16'sd11585, 16'sd0});
    send_bearings({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    send_bearings({16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd3, 16'sd0});    // near parallel
    // huge translation: the depth of the first pair saturates
    load_pose(48'd16384, 48'd16384 << 16, 48'd16384 << 32,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_bearings({16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd40, 16'sd0});
    send_bearings({16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    send_bearings({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384});
    // rotation entries at their extremes: rotated ray saturates
    load_pose({3{16'sh7fff}}, {3{16'sh8000}}, {16'sh7fff, 16'sh8000, 16'sh7fff},
              32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_bearings({16'sd16384, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384});
    send_bearings({-16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0});
    send_bearings({16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    load_pose('0, '0, '0, '0, '0, '0);
    send_bearings({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    load_pose('1, '1, '1, '1, '1, '1);
    send_bearings({16'sd16384, -16'sd16384, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0});
    send_bearings({16'sd1, 16'sd2, 16'sd3, -16'sd3, 16'sd2, 16'sd1});
  endtask

  task automatic test_random_poses();
    for (int p = 0; p < 8; p++) begin
      load_pose(rand_row(), rand_row(), rand_row(), $urandom(), $urandom(),
                ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 1 << 20)) : $urandom());
      for (int i = 0; i < 110; i++) send_bearings(rand_bearings());
    end
  endtask

  task automatic test_full_rate();
    // drain mid-stream with the sender held off, then run with no idling at all
    drain_results();
    for (int i = 0; i < 100; i++) send_bearings(rand_bearings());
    calm = 1'b1;
    for (int i = 0; i < 150; i++) send_bearings(rand_bearings());
    drain_results();
  endtask

  initial begin
    rot_q = '{48'd16384, 48'd16384 << 16, 48'd16384 << 32};
    trans_q = '{32'd0, 32'd0, 32'd0};
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_poses();
    test_full_rate();
    $display("covered %0d bearing pairs over %0d register writes", n_sent, n_cfg);
    $display("checked %0d depths: %0d triangulated, %0d saturated", n_checked, n_ok, n_sat);
    if (n_mismatch == 0 && depth_q.size() == 0) begin
      $display("tb_two_view_depth_triangulation passed");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, depth_q.size());
      $display("tb_two_view_depth_triangulation failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", depth_q.size());
    $display("tb_two_view_depth_triangulation failed");
    $finish;
  end

endmodule
`default_nettype wire
